@@ hw/rtl/werm_pkg.sv @@
// ----------------------------------------------------------------------------
// werm_pkg
// shared constants and types of the windowed event rate meter
// ----------------------------------------------------------------------------
package werm_pkg;

   // default sizing of the timestamp ring
   localparam int RING_DEPTH_DEF = 64;
   localparam int STAMP_BITS_DEF = 48;

   // one minute in milliseconds, scaled to q16.8
   localparam logic [23:0] MS_PER_MIN_Q8 = 24'd15360000;
   // retention beyond the averaging window
   localparam logic [12:0] KEEP_EXTRA_MS = 13'd5000;
   // averaging window after reset
   localparam logic [23:0] WINDOW_RESET  = 24'd60000;
   // saturation value of a rate
   localparam logic [31:0] RATE_MAX      = 32'hFFFF_FFFF;

   // transaction kinds, any other code is a query
   localparam logic [1:0] KIND_RECORD = 2'd0;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } werm_div_stat_type;

endpackage

@@ hw/rtl/windowed_event_rate_meter_core.sv @@
// ----------------------------------------------------------------------------
// windowed_event_rate_meter_core
// event timestamp ring with instantaneous and windowed average rates
// ----------------------------------------------------------------------------
// usage
//   req channel: tuser carries the kind (record, clear, anything else queries),
//   tdata the millisecond time; req_tready is high only while the sequencer
//   is idle, so one transaction is worked on at a time
//   rsp channel: one transaction per request with both rates in q24.8
//   events per minute and the has_data flag in tuser
//   csr port: csr_we writes the averaging window; the user must write it
//   only while idle, the block itself does not enforce this
// a request is taken only once the previous one has handed its result to the
//   response register; the work is set by the ring walks (the scan reads one
//   stamp a cycle) and the shared one-bit-per-cycle divider used twice, whose
//   numerator is NUM_W = clog2(RING_DEPTH+1) + 24 bits wide
// reset: ring emptied through head and count (no clearing pass), window
//   back to 60000 ms, both channels idle
// receiver stall: the response register holds its transaction; the next
//   request is still taken and runs up to its finished result, which waits
//   until the response register frees up
// ----------------------------------------------------------------------------
module windowed_event_rate_meter_core #(
   parameter int RING_DEPTH = werm_pkg::RING_DEPTH_DEF,
   parameter int STAMP_BITS = werm_pkg::STAMP_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [47:0] timestamp_ms
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] instant_rate, [63:32] average_rate
   output logic [0:0]  rsp_tuser,   // [0] has_data
   // configuration
   input  logic        csr_we,
   input  logic [23:0] csr_wdata    // [23:0] avg_window_ms
);

   localparam int IW      = $clog2(RING_DEPTH);
   localparam int CW      = $clog2(RING_DEPTH + 1);
   localparam int SW      = STAMP_BITS;
   // compare width for stamp plus window plus retention
   localparam int CMP_W   = ((SW > 25) ? SW : 25) + 1;
   // divider widths: hit count times one minute, span or stamp gap
   localparam int NUM_W   = CW + 24;
   localparam int DEN_W   = (SW > 24) ? SW : 24;
   localparam int SAT_W   = (NUM_W > 32) ? NUM_W : 32;

   // sequencer states
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_APPLY     = 4'd1;
   localparam logic [3:0] S_PRUNE_RD  = 4'd2;
   localparam logic [3:0] S_PRUNE_CK  = 4'd3;
   localparam logic [3:0] S_SCAN0     = 4'd4;
   localparam logic [3:0] S_SCAN      = 4'd5;
   localparam logic [3:0] S_MUL       = 4'd6;
   localparam logic [3:0] S_DIVI_GO   = 4'd7;
   localparam logic [3:0] S_DIVI_WAIT = 4'd8;
   localparam logic [3:0] S_DIVA_GO   = 4'd9;
   localparam logic [3:0] S_DIVA_WAIT = 4'd10;
   localparam logic [3:0] S_DONE      = 4'd11;

   // ring index step with wraparound
   function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx);
      logic [IW-1:0] res;
      if (idx == IW'(RING_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = idx + IW'(1);
      end
      return res;
   endfunction

   // control state
   logic [3:0]    state_ff, state_in;
   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] issue_k_ff, issue_k_in;
   logic [CW-1:0] proc_k_ff, proc_k_in;
   logic          pend_ff, pend_in;
   logic [23:0]   window_ff, window_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;

   // payload
   logic [1:0]       kind_ff, kind_in;
   logic [SW-1:0]    stamp_ff, stamp_in;
   logic [CW-1:0]    hits_ff, hits_in;
   logic [SW-1:0]    oldest_ff, oldest_in;
   logic [SW-1:0]    last_ff, last_in;
   logic [SW-1:0]    prev_ff, prev_in;
   logic [NUM_W-1:0] prod_ff, prod_in;
   logic [DEN_W-1:0] span_ff, span_in;
   logic [DEN_W-1:0] inst_den_ff, inst_den_in;
   logic             inst_ok_ff, inst_ok_in;
   logic             avg_ok_ff, avg_ok_in;
   logic [31:0]      inst_rate_ff, inst_rate_in;
   logic [31:0]      avg_rate_ff, avg_rate_in;
   logic [31:0]      rsp_inst_ff, rsp_inst_in;
   logic [31:0]      rsp_avg_ff, rsp_avg_in;
   logic             rsp_has_ff, rsp_has_in;

   // timestamp ring
   logic [SW-1:0]    ring_mem [RING_DEPTH];
   logic [SW-1:0]    rd_data_ff;
   logic             mem_we;
   logic [IW-1:0]    mem_waddr;
   logic             mem_re;
   logic [IW-1:0]    mem_raddr;

   // record placement
   logic             ring_full;
   logic [IW-1:0]    head_adj;
   logic [CW-1:0]    cnt_adj;
   logic [CW:0]      wr_sum;

   // per-stamp tests
   logic             stale;
   logic             hit;
   logic             scan_issue;
   logic [SW-1:0]    gap;
   logic [DEN_W-1:0] diff_ext;
   logic [DEN_W-1:0] win_ext;
   logic [SAT_W-1:0] avg_quo_ext;

   // shared divider
   logic                        div_start;
   logic [NUM_W-1:0]            div_numer;
   logic [DEN_W-1:0]            div_denom;
   werm_pkg::werm_div_stat_type div_stat;
   logic [NUM_W-1:0]            div_quo;

   werm_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (div_denom),
      .div_stat (div_stat),
      .quotient (div_quo)
   );

   // the same unit serves the gap division and then the window division
   assign div_numer = (state_ff == S_DIVA_GO) ? prod_ff : NUM_W'(werm_pkg::MS_PER_MIN_Q8);
   assign div_denom = (state_ff == S_DIVA_GO) ? span_ff : inst_den_ff;

   always_comb begin
      // a full ring drops its oldest entry before the new stamp goes in
      ring_full = (count_ff == CW'(RING_DEPTH));
      head_adj  = ring_full ? next_idx(head_ff) : head_ff;
      cnt_adj   = ring_full ? CW'(RING_DEPTH - 1) : count_ff;
      wr_sum    = (CW+1)'(head_adj) + (CW+1)'(cnt_adj);
      if (wr_sum >= (CW+1)'(RING_DEPTH)) begin
         wr_sum = wr_sum - (CW+1)'(RING_DEPTH);
      end

      // front entry older than the retention span
      stale = ((CMP_W'(rd_data_ff) + CMP_W'(window_ff) + CMP_W'(werm_pkg::KEEP_EXTRA_MS))
               < CMP_W'(stamp_ff));
      // stamp inside the averaging window
      hit   = ((CMP_W'(rd_data_ff) + CMP_W'(window_ff)) >= CMP_W'(stamp_ff));

      scan_issue = (issue_k_ff != count_ff);

      // span: now minus oldest, at least one, at most the window when that is nonzero
      gap      = stamp_ff - oldest_ff;
      diff_ext = DEN_W'(gap);
      win_ext  = DEN_W'(window_ff);

      avg_quo_ext = SAT_W'(div_quo);
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      issue_k_in    = issue_k_ff;
      proc_k_in     = proc_k_ff;
      pend_in       = pend_ff;
      window_in     = csr_we ? csr_wdata : window_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;

      kind_in      = kind_ff;
      stamp_in     = stamp_ff;
      hits_in      = hits_ff;
      oldest_in    = oldest_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      prod_in      = prod_ff;
      span_in      = span_ff;
      inst_den_in  = inst_den_ff;
      inst_ok_in   = inst_ok_ff;
      avg_ok_in    = avg_ok_ff;
      inst_rate_in = inst_rate_ff;
      avg_rate_in  = avg_rate_ff;
      rsp_inst_in  = rsp_inst_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_has_in   = rsp_has_ff;

      mem_we    = 1'b0;
      mem_waddr = IW'(wr_sum);
      mem_re    = 1'b0;
      mem_raddr = head_ff;
      div_start = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser;
               stamp_in = SW'(req_tdata);
               state_in = S_APPLY;
            end
         end

         S_APPLY: begin
            case (kind_ff)
               werm_pkg::KIND_RECORD: begin
                  mem_we   = 1'b1;
                  head_in  = head_adj;
                  count_in = cnt_adj + CW'(1);
                  state_in = S_PRUNE_RD;
               end
               werm_pkg::KIND_CLEAR: begin
                  head_in  = '0;
                  count_in = '0;
                  state_in = S_SCAN0;
               end
               default: begin
                  // query: ring untouched
                  state_in = S_SCAN0;
               end
            endcase
         end

         // walk the front while it is past the retention span
         S_PRUNE_RD: begin
            if (count_ff == '0) begin
               state_in = S_SCAN0;
            end else begin
               mem_re   = 1'b1;
               state_in = S_PRUNE_CK;
            end
         end

         S_PRUNE_CK: begin
            if (stale) begin
               head_in  = next_idx(head_ff);
               count_in = count_ff - CW'(1);
               state_in = S_PRUNE_RD;
            end else begin
               state_in = S_SCAN0;
            end
         end

         S_SCAN0: begin
            ptr_in     = head_ff;
            issue_k_in = '0;
            proc_k_in  = '0;
            pend_in    = 1'b0;
            hits_in    = '0;
            oldest_in  = stamp_ff;
            state_in   = S_SCAN;
         end

         // one read issued and one stamp evaluated per cycle
         S_SCAN: begin
            if (scan_issue) begin
               mem_re     = 1'b1;
               mem_raddr  = ptr_ff;
               ptr_in     = next_idx(ptr_ff);
               issue_k_in = issue_k_ff + CW'(1);
            end
            pend_in = scan_issue;
            if (pend_ff) begin
               if (hit) begin
                  hits_in = hits_ff + CW'(1);
                  if (rd_data_ff < oldest_ff) begin
                     oldest_in = rd_data_ff;
                  end
               end
               if (({1'b0, proc_k_ff} + (CW+1)'(1)) == {1'b0, count_ff}) begin
                  last_in = rd_data_ff;
               end
               if (({1'b0, proc_k_ff} + (CW+1)'(2)) == {1'b0, count_ff}) begin
                  prev_in = rd_data_ff;
               end
               proc_k_in = proc_k_ff + CW'(1);
            end
            if (!scan_issue && !pend_ff) begin
               state_in = S_MUL;
            end
         end

         S_MUL: begin
            prod_in    = NUM_W'(hits_ff) * NUM_W'(werm_pkg::MS_PER_MIN_Q8);
            inst_ok_in = (count_ff >= CW'(2)) && (last_ff > prev_ff);
            avg_ok_in  = (window_ff != '0) && (hits_ff != '0);
            // a zero divisor never reaches the divider
            inst_den_in = inst_ok_in ? DEN_W'(last_ff - prev_ff) : DEN_W'(1);
            if (diff_ext == '0) begin
               span_in = DEN_W'(1);
            end else if (diff_ext > win_ext) begin
               span_in = (win_ext == '0) ? DEN_W'(1) : win_ext;
            end else begin
               span_in = diff_ext;
            end
            state_in = S_DIVI_GO;
         end

         S_DIVI_GO: begin
            div_start = 1'b1;
            state_in  = S_DIVI_WAIT;
         end

         S_DIVI_WAIT: begin
            if (div_stat.done) begin
               // gap quotient stays at or below one minute in q8
               inst_rate_in = inst_ok_ff ? 32'(div_quo) : '0;
               state_in     = S_DIVA_GO;
            end
         end

         S_DIVA_GO: begin
            div_start = 1'b1;
            state_in  = S_DIVA_WAIT;
         end

         S_DIVA_WAIT: begin
            if (div_stat.done) begin
               if (!avg_ok_ff) begin
                  avg_rate_in = '0;
               end else if (avg_quo_ext > SAT_W'(werm_pkg::RATE_MAX)) begin
                  avg_rate_in = werm_pkg::RATE_MAX;
               end else begin
                  avg_rate_in = avg_quo_ext[31:0];
               end
               state_in = S_DONE;
            end
         end

         // hand over once the response register is free
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_inst_in   = inst_rate_ff;
               rsp_avg_in    = avg_rate_ff;
               rsp_has_in    = (count_ff != '0);
               rsp_tvalid_in = 1'b1;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         ptr_ff        <= '0;
         issue_k_ff    <= '0;
         proc_k_ff     <= '0;
         pend_ff       <= 1'b0;
         window_ff     <= werm_pkg::WINDOW_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         ptr_ff        <= ptr_in;
         issue_k_ff    <= issue_k_in;
         proc_k_ff     <= proc_k_in;
         pend_ff       <= pend_in;
         window_ff     <= window_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      stamp_ff     <= stamp_in;
      hits_ff      <= hits_in;
      oldest_ff    <= oldest_in;
      last_ff      <= last_in;
      prev_ff      <= prev_in;
      prod_ff      <= prod_in;
      span_ff      <= span_in;
      inst_den_ff  <= inst_den_in;
      inst_ok_ff   <= inst_ok_in;
      avg_ok_ff    <= avg_ok_in;
      inst_rate_ff <= inst_rate_in;
      avg_rate_ff  <= avg_rate_in;
      rsp_inst_ff  <= rsp_inst_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_has_ff   <= rsp_has_in;
   end

   // ring storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= stamp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= ring_mem[mem_raddr];
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_avg_ff, rsp_inst_ff};
   assign rsp_tuser  = rsp_has_ff;

   // ring never holds more than its depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(RING_DEPTH))
      else $error("ring count above depth");

   // an accepted request keeps the block busy in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while still working");

   // a clear empties the ring
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY && kind_ff == werm_pkg::KIND_CLEAR) |=> (count_ff == '0))
      else $error("clear left stamps behind");

   // the divider only runs while the sequencer waits on it
   assert property (@(posedge clock) disable iff (reset)
      (div_stat.busy || div_stat.done) |->
         (state_ff == S_DIVI_WAIT || state_ff == S_DIVA_WAIT))
      else $error("divider active outside a wait state");

endmodule

@@ hw/rtl/werm_divider.sv @@
// ----------------------------------------------------------------------------
// werm_divider
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module werm_divider #(
   parameter int NUM_W = 31,
   parameter int DEN_W = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [NUM_W-1:0]              numer,
   input  logic [DEN_W-1:0]              denom,
   output werm_pkg::werm_div_stat_type   div_stat,
   output logic [NUM_W-1:0]              quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;

   logic [DEN_W:0]   shifted;
   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      trial   = shifted - {1'b0, den_ff};
      fits    = (shifted >= {1'b0, den_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         quo_in  = numer;
         den_in  = denom;
      end else if (busy_ff) begin
         rem_in = fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_stat.busy = busy_ff;
   assign div_stat.done = done_ff;
   assign quotient      = quo_ff;

endmodule
